FILE: hw/rtl/btgr_pkg.sv
// Shared types and constants for the bitmap text glyph rasterizer.
// Used by btgr_ctrl, btgr_datapath and the top level; depends on nothing.
package btgr_pkg;

  localparam int GlyphBytes = 1024;
  localparam int CodeCount  = 256;
  localparam int MaxGlyphW  = 8;
  localparam int MaxGlyphH  = 8;
  localparam int ScreenLimit = 1024;

  // Input operations.
  localparam logic [1:0] OP_GLYPH_WRITE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE_WRITE = 2'd1;
  localparam logic [1:0] OP_DRAW          = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_FIRST_CODE    = 3'd2;
  localparam logic [2:0] CFG_LAST_CODE     = 3'd3;
  localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_GLYPH_HEIGHT  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic wr_glyph;
    logic wr_advance;
    logic draw_load;
    logic row_read;
    logic scan;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic empty_cell;
    logic col_last;
    logic row_last;
  } status_t;

endpackage

FILE: hw/rtl/btgr_ctrl.sv
// Controller state machine of the glyph rasterizer: sequences row reads and
// the column scan. Depends on btgr_pkg; drives btgr_datapath through cmd_t.
module btgr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  btgr_pkg::status_t status,
  output btgr_pkg::cmd_t    cmd,
  output logic              busy
);

  btgr_pkg::state_t state, state_next;
  logic accept;

  assign busy   = (state != btgr_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btgr_pkg::ST_IDLE: begin
        if (accept && op == btgr_pkg::OP_DRAW && status.in_range) begin
          state_next = status.empty_cell ? btgr_pkg::ST_FLUSH : btgr_pkg::ST_READ;
        end
      end
      btgr_pkg::ST_READ: begin
        state_next = btgr_pkg::ST_SCAN;
      end
      btgr_pkg::ST_SCAN: begin
        if (status.col_last) begin
          state_next = status.row_last ? btgr_pkg::ST_FLUSH : btgr_pkg::ST_READ;
        end
      end
      btgr_pkg::ST_FLUSH: begin
        state_next = btgr_pkg::ST_IDLE;
      end
      default: state_next = btgr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      btgr_pkg::ST_IDLE: begin
        cmd.wr_glyph   = accept && op == btgr_pkg::OP_GLYPH_WRITE;
        cmd.wr_advance = accept && op == btgr_pkg::OP_ADVANCE_WRITE;
        cmd.draw_load  = accept && op == btgr_pkg::OP_DRAW;
      end
      btgr_pkg::ST_READ:  cmd.row_read = 1'b1;
      btgr_pkg::ST_SCAN:  cmd.scan     = 1'b1;
      btgr_pkg::ST_FLUSH: cmd.flush    = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/btgr_datapath.sv
// Datapath of the glyph rasterizer: configuration registers, glyph and
// advance memories, pen, row/column counters and the pixel output stage.
// Depends on btgr_pkg; controlled by btgr_ctrl.
module btgr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  input  logic [9:0]        table_addr,
  input  logic [7:0]        table_data,
  input  logic [7:0]        char_code,
  input  logic              set_pen,
  input  logic [15:0]       pen_x,
  input  logic [15:0]       pen_y,
  input  logic [15:0]       color,
  input  btgr_pkg::cmd_t    cmd,
  output btgr_pkg::status_t status,
  output logic              pixel_valid,
  output logic [9:0]        pixel_x,
  output logic [9:0]        pixel_y,
  output logic [15:0]       pixel_color,
  output logic              last_pixel
);

  logic [10:0] screen_width, screen_height;
  logic [7:0]  first_code, last_code;
  logic [3:0]  glyph_width, glyph_height;

  logic [7:0] glyph_mem [btgr_pkg::GlyphBytes];
  logic [7:0] advance_mem [btgr_pkg::CodeCount];
  logic [7:0] glyph_q;
  logic       glyph_oob;
  logic [7:0] advance;

  logic [15:0] cursor_x, cursor_y;
  logic [15:0] color_q;
  logic [10:0] base;
  logic [2:0]  row, col;

  logic        pend_valid;
  logic [9:0]  pend_x, pend_y;

  logic [3:0]  gw_eff, gh_eff;
  logic [10:0] sw_eff, sh_eff;
  logic [7:0]  idx;
  logic [11:0] base_calc;
  logic [10:0] row_addr;
  logic [7:0]  row_byte;
  logic [15:0] px, py;
  logic        hit;

  // Sizes saturate to the hardware limits.
  assign gw_eff = (glyph_width > 4'(btgr_pkg::MaxGlyphW)) ? 4'(btgr_pkg::MaxGlyphW)
                                                          : glyph_width;
  assign gh_eff = (glyph_height > 4'(btgr_pkg::MaxGlyphH)) ? 4'(btgr_pkg::MaxGlyphH)
                                                           : glyph_height;
  assign sw_eff = (screen_width > 11'(btgr_pkg::ScreenLimit)) ? 11'(btgr_pkg::ScreenLimit)
                                                              : screen_width;
  assign sh_eff = (screen_height > 11'(btgr_pkg::ScreenLimit)) ? 11'(btgr_pkg::ScreenLimit)
                                                               : screen_height;

  assign idx       = char_code - first_code;
  assign base_calc = 12'(idx) * 12'(gh_eff);
  assign row_addr  = base + 11'(row);

  assign status.in_range   = (char_code >= first_code) && (char_code <= last_code);
  assign status.empty_cell = (gw_eff == 4'd0) || (gh_eff == 4'd0);
  assign status.col_last   = ({1'b0, col} == gw_eff - 4'd1);
  assign status.row_last   = ({1'b0, row} == gh_eff - 4'd1);

  // Rows past the end of the store read as blank.
  assign row_byte = glyph_oob ? 8'd0 : glyph_q;
  assign px       = cursor_x + 16'(col);
  assign py       = cursor_y + 16'(row);
  assign hit      = row_byte[col] && (px < 16'(sw_eff)) && (py < 16'(sh_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd240;
      screen_height <= 11'd320;
      first_code    <= 8'd32;
      last_code     <= 8'd126;
      glyph_width   <= 4'd8;
      glyph_height  <= 4'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        btgr_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        btgr_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        btgr_pkg::CFG_FIRST_CODE:    first_code    <= cfg_data[7:0];
        btgr_pkg::CFG_LAST_CODE:     last_code     <= cfg_data[7:0];
        btgr_pkg::CFG_GLYPH_WIDTH:   glyph_width   <= cfg_data[3:0];
        btgr_pkg::CFG_GLYPH_HEIGHT:  glyph_height  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_glyph) begin
      glyph_mem[table_addr] <= table_data;
    end
    if (cmd.row_read) begin
      glyph_q <= glyph_mem[row_addr[9:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_advance && table_addr[9:8] == 2'd0) begin
      advance_mem[table_addr[7:0]] <= table_data;
    end
    if (cmd.draw_load) begin
      advance <= advance_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_read) begin
      glyph_oob <= row_addr[10];
    end
    if (cmd.draw_load) begin
      color_q <= color;
      base    <= base_calc[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= 16'd0;
      cursor_y <= 16'd0;
    end else if (cmd.draw_load && set_pen) begin
      cursor_x <= pen_x;
      cursor_y <= pen_y;
    end else if (cmd.flush) begin
      cursor_x <= cursor_x + 16'(advance) + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 3'd0;
      col <= 3'd0;
    end else if (cmd.draw_load) begin
      row <= 3'd0;
      col <= 3'd0;
    end else if (cmd.scan) begin
      if (status.col_last) begin
        col <= 3'd0;
        row <= row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
  end

  // One pixel is held back so that the final write of a character can carry
  // last_pixel once the scan is known to be over.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= 1'b0;
      if (cmd.scan && hit) begin
        pend_valid <= 1'b1;
        pend_x     <= px[9:0];
        pend_y     <= py[9:0];
        if (pend_valid) begin
          pixel_valid <= 1'b1;
          pixel_x     <= pend_x;
          pixel_y     <= pend_y;
          pixel_color <= color_q;
          last_pixel  <= 1'b0;
        end
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          pixel_valid <= 1'b1;
          pixel_x     <= pend_x;
          pixel_y     <= pend_y;
          pixel_color <= color_q;
          last_pixel  <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/bitmap_text_glyph_rasterizer.sv
// Top level of the bitmap text glyph rasterizer.
// Depends on btgr_pkg, btgr_ctrl and btgr_datapath.
//
// A glyph byte or advance width write leaves the block idle, so the next item
// may start in the following cycle. A draw of a character in the font reads
// one glyph memory row and then scans its columns, one column per cycle, for
// each of its H rows, then flushes and advances the pen; W and H are the glyph
// width and height limited to 8. When W or H is zero the draw only advances
// the pen. A character outside the font finishes in its accept cycle. Pixel
// writes appear one per cycle at most, each strobed by pixel_valid for exactly
// one cycle; the receiver must take every one.
module bitmap_text_glyph_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [9:0]  table_addr,
  input  logic [7:0]  table_data,
  input  logic [7:0]  char_code,
  input  logic        set_pen,
  input  logic [15:0] pen_x,
  input  logic [15:0] pen_y,
  input  logic [15:0] color,
  output logic        pixel_valid,
  output logic [9:0]  pixel_x,
  output logic [9:0]  pixel_y,
  output logic [15:0] pixel_color,
  output logic        last_pixel
);

  btgr_pkg::cmd_t    cmd;
  btgr_pkg::status_t status;

  btgr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  btgr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .table_addr  (table_addr),
    .table_data  (table_data),
    .char_code   (char_code),
    .set_pen     (set_pen),
    .pen_x       (pen_x),
    .pen_y       (pen_y),
    .color       (color),
    .cmd         (cmd),
    .status      (status),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

  // Pixels only come out of a draw that was running in the cycle before.
  a_pixel_from_draw: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> $past(busy))
    else $error("pixel write without a draw in progress");

  // A newly accepted item never sees a pixel in the following cycle.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !pixel_valid)
    else $error("pixel write right after an accept");

  // The final pixel of a character is followed by a quiet cycle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && last_pixel) |=> !pixel_valid)
    else $error("pixel write right after the final pixel");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for bitmap_text_glyph_rasterizer: loads glyph and advance tables,
// draws characters under a series of screen and font settings, and checks every pixel write
// against a behavioral rasterizer held in a small scoreboard class. Depends on btgr_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int MaxPixels   = 64;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] rgb;
    logic        tail;
  } pixel_t;

  class pixel_scoreboard;
    logic [7:0]  glyph_mem [btgr_pkg::GlyphBytes];
    logic [7:0]  advance_mem [btgr_pkg::CodeCount];
    bit          glyph_set [btgr_pkg::GlyphBytes];
    bit          advance_set [btgr_pkg::CodeCount];
    logic [15:0] pen_col;
    logic [15:0] pen_row;
    logic [10:0] scr_w;
    logic [10:0] scr_h;
    logic [7:0]  code_lo;
    logic [7:0]  code_hi;
    logic [3:0]  cell_w;
    logic [3:0]  cell_h;
    pixel_t      pixels_due[$];
    int          errors;
    int          shown;

    function new();
      pen_col = '0;
      pen_row = '0;
      scr_w   = 11'd240;
      scr_h   = 11'd320;
      code_lo = 8'd32;
      code_hi = 8'd126;
      cell_w  = 4'd8;
      cell_h  = 4'd8;
      errors  = 0;
      shown   = 0;
    endfunction

    function int unsigned cell_cols();
      return (cell_w > btgr_pkg::MaxGlyphW) ? btgr_pkg::MaxGlyphW : cell_w;
    endfunction

    function int unsigned cell_rows();
      return (cell_h > btgr_pkg::MaxGlyphH) ? btgr_pkg::MaxGlyphH : cell_h;
    endfunction

    function bit in_font(logic [7:0] code);
      return (code >= code_lo) && (code <= code_hi);
    endfunction

    function void write_reg(logic [2:0] idx, logic [10:0] val);
      case (idx)
        btgr_pkg::CFG_SCREEN_WIDTH:  scr_w = val;
        btgr_pkg::CFG_SCREEN_HEIGHT: scr_h = val;
        btgr_pkg::CFG_FIRST_CODE:    code_lo = val[7:0];
        btgr_pkg::CFG_LAST_CODE:     code_hi = val[7:0];
        btgr_pkg::CFG_GLYPH_WIDTH:   cell_w = val[3:0];
        btgr_pkg::CFG_GLYPH_HEIGHT:  cell_h = val[3:0];
        default: ;
      endcase
    endfunction

    // Updates the tables and pen for one accepted item and queues the pixel writes it causes.
    function void accept_item(logic [1:0] op, logic [9:0] addr, logic [7:0] data,
                              logic [7:0] code, logic load_pen, logic [15:0] x0,
                              logic [15:0] y0, logic [15:0] rgb);
      int unsigned w, h, bpr, sw, sh, idx, base, col, byte_addr;
      logic [7:0]  line;
      logic [15:0] px, py;
      pixel_t      burst[$];
      pixel_t      p;
      case (op)
        btgr_pkg::OP_GLYPH_WRITE: begin
          glyph_mem[addr] = data;
          glyph_set[addr] = 1'b1;
        end
        btgr_pkg::OP_ADVANCE_WRITE: begin
          if (addr < btgr_pkg::CodeCount) begin
            advance_mem[addr] = data;
            advance_set[addr] = 1'b1;
          end
        end
        btgr_pkg::OP_DRAW: begin
          if (load_pen) begin
            pen_col = x0;
            pen_row = y0;
          end
          if (in_font(code)) begin
            w    = cell_cols();
            h    = cell_rows();
            bpr  = (w + 7) / 8;
            sw   = (scr_w > btgr_pkg::ScreenLimit) ? btgr_pkg::ScreenLimit : scr_w;
            sh   = (scr_h > btgr_pkg::ScreenLimit) ? btgr_pkg::ScreenLimit : scr_h;
            idx  = code - code_lo;
            base = idx * h * bpr;
            for (int r = 0; r < h; r++) begin
              for (int b = 0; b < bpr; b++) begin
                byte_addr = base + r * bpr + b;
                // Glyph bytes past the end of the store read as blank.
                line = (byte_addr < btgr_pkg::GlyphBytes) ? glyph_mem[byte_addr] : 8'h00;
                for (int k = 0; k < 8; k++) begin
                  col = b * 8 + k;
                  if (col < w && line[k]) begin
                    px = pen_col + 16'(col);
                    py = pen_row + 16'(r);
                    if (px < sw && py < sh && burst.size() < MaxPixels) begin
                      p.x    = px[9:0];
                      p.y    = py[9:0];
                      p.rgb  = rgb;
                      p.tail = 1'b0;
                      burst.push_back(p);
                    end
                  end
                end
              end
            end
            if (burst.size() > 0) burst[burst.size() - 1].tail = 1'b1;
            foreach (burst[i]) pixels_due.push_back(burst[i]);
            pen_col = pen_col + 16'(advance_mem[idx]) + 16'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("pixel error: unexpected write x=%0d y=%0d color=%h last=%b",
                   got.x, got.y, got.rgb, got.tail);
        end
        return;
      end
      want = pixels_due.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display({"pixel error: expected x=%0d y=%0d color=%h last=%b, ",
                    "got x=%0d y=%0d color=%h last=%b"},
                   want.x, want.y, want.rgb, want.tail, got.x, got.y, got.rgb, got.tail);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = '0;
  logic [9:0]  table_addr = '0;
  logic [7:0]  table_data = '0;
  logic [7:0]  char_code = '0;
  logic        set_pen = 1'b0;
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  logic [15:0] color = '0;
  logic        pixel_valid;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] pixel_color;
  logic        last_pixel;

  pixel_scoreboard sb;
  int items_sent = 0;
  int idle_pct = 0;

  bitmap_text_glyph_rasterizer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .table_addr  (table_addr),
    .table_data  (table_data),
    .char_code   (char_code),
    .set_pen     (set_pen),
    .pen_x       (pen_x),
    .pen_y       (pen_y),
    .color       (color),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid === 1'b1) begin
      sb.check_pixel({pixel_x, pixel_y, pixel_color, last_pixel});
    end
  end

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Leaves start high on return so that a following item goes out without a bubble.
  task automatic send_item(input logic [1:0] o, input logic [9:0] a, input logic [7:0] d,
                           input logic [7:0] c, input logic sp, input logic [15:0] x0,
                           input logic [15:0] y0, input logic [15:0] rgb);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 3));
    start      <= 1'b1;
    op         <= o;
    table_addr <= a;
    table_data <= d;
    char_code  <= c;
    set_pen    <= sp;
    pen_x      <= x0;
    pen_y      <= y0;
    color      <= rgb;
    do @(posedge clk); while (busy !== 1'b0);
    sb.accept_item(o, a, d, c, sp, x0, y0, rgb);
    if (o != OP_RESERVED) items_sent++;
  endtask

  // Makes sure that every table entry a draw of this code reads has been written.
  task automatic load_glyph(input logic [7:0] code);
    int unsigned idx, rows, addr;
    if (!sb.in_font(code)) return;
    idx  = code - sb.code_lo;
    rows = sb.cell_rows();
    for (int r = 0; r < rows; r++) begin
      addr = idx * rows + r;
      if (addr < btgr_pkg::GlyphBytes && !sb.glyph_set[addr]) begin
        send_item(btgr_pkg::OP_GLYPH_WRITE, 10'(addr), 8'($urandom), 8'($urandom),
                  1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    if (!sb.advance_set[idx]) begin
      send_item(btgr_pkg::OP_ADVANCE_WRITE, 10'(idx),
                ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 9)) : 8'($urandom),
                8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Waits until every pixel has come out and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pixels_due.size() != 0 || busy !== 1'b0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [10:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [10:0] w, input logic [10:0] h,
                                input logic [7:0] lo, input logic [7:0] hi,
                                input logic [3:0] cw, input logic [3:0] ch);
    settle();
    cfg_put(btgr_pkg::CFG_SCREEN_WIDTH, w);
    cfg_put(btgr_pkg::CFG_SCREEN_HEIGHT, h);
    cfg_put(btgr_pkg::CFG_FIRST_CODE, 11'(lo));
    cfg_put(btgr_pkg::CFG_LAST_CODE, 11'(hi));
    cfg_put(btgr_pkg::CFG_GLYPH_WIDTH, 11'(cw));
    cfg_put(btgr_pkg::CFG_GLYPH_HEIGHT, 11'(ch));
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  shape [8] = '{8'hFF, 8'h81, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h00, 8'hFF};
    logic [10:0] set_w, set_h;
    logic [7:0]  set_lo, set_hi, code;
    logic [3:0]  set_cw, set_ch;
    logic [15:0] x0, y0;
    logic        load_pen;
    int          roll, span, quota, target;

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset font: 8x8 cells, codes 32 to 126, 240x320 screen.
    send_item(OP_RESERVED, 10'h3FF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int r = 0; r < 8; r++) begin
      send_item(btgr_pkg::OP_GLYPH_WRITE, 10'(264 + r), shape[r], 8'h00, 1'b0, '0, '0, '0);
    end
    send_item(btgr_pkg::OP_ADVANCE_WRITE, 10'd33, 8'd5, 8'h00, 1'b0, '0, '0, '0);
    // Advance index past the table is dropped.
    send_item(btgr_pkg::OP_ADVANCE_WRITE, 10'h3FF, 8'hFF, 8'h00, 1'b0, '0, '0, '0);
    load_glyph(8'd32);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd65, 1'b1, 16'd0, 16'd0, 16'hFFFF);
    send_item(btgr_pkg::OP_DRAW, 10'h3FF, 8'hFF, 8'd65, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
    // Pen near the top of the 16-bit range wraps onto the screen.
    send_item(btgr_pkg::OP_DRAW, 10'h155, 8'h5A, 8'd65, 1'b1, 16'hFFFD, 16'hFFFC, 16'h1234);
    send_item(btgr_pkg::OP_DRAW, 10'h2AA, 8'hA5, 8'd65, 1'b1, 16'd236, 16'd316, 16'hA5A5);
    // Codes outside the font still load the pen but draw nothing and do not advance.
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd31, 1'b1, 16'd10, 16'd10, 16'h5A5A);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd32, 1'b0, 16'd0, 16'd0, 16'h00FF);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd127, 1'b0, 16'd0, 16'd0, 16'hFF00);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd255, 1'b0, 16'd0, 16'd0, 16'hF00F);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd0, 1'b0, 16'd0, 16'd0, 16'h0FF0);
    send_item(btgr_pkg::OP_DRAW, 10'h000, 8'h00, 8'd65, 1'b0, 16'd0, 16'd0, 16'h7E7E);

    for (int ph = 0; ph < 10; ph++) begin
      set_w  = 11'($urandom_range(16, 1024));
      set_h  = 11'($urandom_range(16, 1024));
      set_lo = 8'($urandom_range(0, 100));
      set_hi = set_lo + 8'($urandom_range(10, 155));
      set_cw = 4'($urandom_range(1, 8));
      set_ch = 4'($urandom_range(1, 8));
      quota  = 45;
      case (ph)
        0: begin
          set_w = 11'd1024; set_h = 11'd1024; set_lo = 8'd0; set_hi = 8'd255;
          set_cw = 4'd8; set_ch = 4'd8;
        end
        1: begin
          // Oversized screen and cell saturate.
          set_w = 11'd2047; set_h = 11'd1500; set_lo = 8'd65; set_hi = 8'd90;
          set_cw = 4'd15; set_ch = 4'd15;
        end
        2: begin
          // First code above last code: the font is empty.
          set_w = 11'd37; set_h = 11'd700; set_lo = 8'd200; set_hi = 8'd100;
          set_cw = 4'd3; set_ch = 4'd5; quota = 10;
        end
        4: begin
          set_w = 11'd1; set_h = 11'd1; set_lo = 8'd255; set_hi = 8'd255;
          set_cw = 4'd1; set_ch = 4'd1; quota = 20;
        end
        5: begin
          set_w = 11'd0; quota = 10;
        end
        6: begin
          set_w = 11'd300; set_h = 11'd200; set_lo = 8'd0; set_hi = 8'd0;
          set_cw = 4'd5; set_ch = 4'd8; quota = 30;
        end
        7: begin
          set_w = 11'd1024; set_h = 11'd1024; set_lo = 8'd0; set_hi = 8'd255;
          set_cw = 4'd0; set_ch = 4'd6; quota = 10;
        end
        8: begin
          set_w = 11'd1024; set_h = 11'd0; set_lo = 8'd0; set_hi = 8'd255;
          set_cw = 4'd7; set_ch = 4'd0; quota = 10;
        end
        9: quota = 50;
        default: ;
      endcase
      apply_settings(set_w, set_h, set_lo, set_hi, set_cw, set_ch);
      idle_pct = (ph < 3) ? 13 : (ph < 6) ? 63 : 0;
      target = items_sent + quota;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          send_item(OP_RESERVED, 10'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
        end else if (roll < 13) begin
          send_item(btgr_pkg::OP_GLYPH_WRITE, 10'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (roll < 20) begin
          send_item(btgr_pkg::OP_ADVANCE_WRITE, 10'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          // Mostly codes from a small set near the start of the font, so glyphs get reused.
          roll = $urandom_range(0, 99);
          if (sb.code_lo <= sb.code_hi && roll < 85) begin
            span = sb.code_hi - sb.code_lo;
            code = sb.code_lo + 8'((roll < 60) ? $urandom_range(0, (span < 11) ? span : 11)
                                               : $urandom_range(0, span));
          end else begin
            code = 8'($urandom);
          end
          load_glyph(code);
          load_pen = ($urandom_range(0, 99) < 40);
          roll = $urandom_range(0, 99);
          if (roll < 65) begin
            x0 = 16'($urandom_range(0, sb.scr_w));
            y0 = 16'($urandom_range(0, sb.scr_h));
          end else if (roll < 80) begin
            x0 = 16'hFFF8 + 16'($urandom_range(0, 7));
            y0 = 16'hFFF8 + 16'($urandom_range(0, 7));
          end else begin
            x0 = 16'($urandom);
            y0 = 16'($urandom);
          end
          send_item(btgr_pkg::OP_DRAW, 10'($urandom), 8'($urandom), code, load_pen, x0, y0,
                    16'($urandom));
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("bitmap_text_glyph_rasterizer: match");
    end else begin
      $display("bitmap_text_glyph_rasterizer: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bitmap_text_glyph_rasterizer: mismatch");
    $finish;
  end

endmodule
